// ===== design/rmt_pkg.sv =====
package rmt_pkg;

  localparam int W_C       = 32;
  localparam int W_S       = 33;
  localparam int W_P       = 65;
  localparam int W_DOT     = 68;
  localparam int W_DEN     = 136;
  localparam int W_NUM     = 172;
  localparam int W_DD      = 137;
  localparam int Q_BITS    = 32;
  localparam int MUL_DIGIT = 16;
  localparam int DIV_LAT   = Q_BITS + 3;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef logic signed [W_C-1:0] coord_t;
  typedef logic signed [W_S-1:0] sum_t;

  typedef struct packed {
    logic signed [31:0] origin_one_x;
    logic signed [31:0] origin_one_y;
    logic signed [31:0] origin_one_z;
    logic signed [31:0] direction_one_x;
    logic signed [31:0] direction_one_y;
    logic signed [31:0] direction_one_z;
    logic signed [31:0] origin_two_x;
    logic signed [31:0] origin_two_y;
    logic signed [31:0] origin_two_z;
    logic signed [31:0] direction_two_x;
    logic signed [31:0] direction_two_y;
    logic signed [31:0] direction_two_z;
  } rays_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               rays_parallel;
  } point_t;

  typedef struct packed {
    sum_t   [2:0] s;
    coord_t [2:0] d1;
    coord_t [2:0] d2;
  } side_t;

  typedef struct packed {
    logic                    par;
    logic signed [W_DEN-1:0] den;
    logic signed [W_DEN-1:0] n1;
    logic signed [W_DEN-1:0] n2;
    side_t                   side;
  } job_t;

endpackage

// ===== design/rmt_mul.sv =====
module rmt_mul #(
  parameter int WA    = 8,
  parameter int WB    = 8,
  parameter int DIGIT = 4
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NS = (WB + DIGIT - 1) / DIGIT;
  localparam int BW = NS * DIGIT;
  localparam int WP = WA + BW;

  logic signed [BW-1:0] bx;
  logic signed [WP-1:0] acc [NS];
  logic signed [WA-1:0] ar  [NS-1];
  logic signed [BW-1:0] br  [NS-1];

  assign bx = BW'(b);

  function automatic logic signed [WP-1:0] pp(logic signed [WA-1:0] x,
                                              logic [DIGIT-1:0] dgt, logic top);
    logic signed [DIGIT:0]    dg;
    logic signed [WA+DIGIT:0] m;
    dg = top ? {dgt[DIGIT-1], dgt} : {1'b0, dgt};
    m  = x * dg;
    return WP'(m);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      acc[0] <= pp(a, bx[DIGIT-1:0], 1'b0);
      ar[0]  <= a;
      br[0]  <= bx;
      for (int i = 1; i < NS; i++) begin
        acc[i] <= acc[i-1] + (pp(ar[i-1], br[i-1][i*DIGIT +: DIGIT], i == NS - 1)
                  <<< (i * DIGIT));
      end
      for (int i = 1; i < NS - 1; i++) begin
        ar[i] <= ar[i-1];
        br[i] <= br[i-1];
      end
    end
  end

  assign p = acc[NS-1][WA+WB-1:0];

endmodule

// ===== design/rmt_div.sv =====
module rmt_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [rmt_pkg::W_NUM-1:0]  num,
  input  logic        [rmt_pkg::W_DD-1:0]   dd,
  output logic        [31:0]                res
);

  localparam int WN = rmt_pkg::W_NUM;
  localparam int WD = rmt_pkg::W_DD;
  localparam int QB = rmt_pkg::Q_BITS;

  typedef struct packed {
    logic          neg;
    logic          big;
    logic [WD-1:0] dd;
    logic [WD-1:0] rem;
    logic [QB-1:0] low;
    logic [QB-1:0] q;
  } dstep_t;

  logic          neg_a;
  logic [WN-1:0] mag_a;
  logic [WD-1:0] dd_a;
  dstep_t        st [QB+1];
  dstep_t        fin;
  logic          rnz;
  logic [QB:0]   qq;

  function automatic dstep_t div_step(dstep_t x);
    logic [WD:0] r2;
    logic [WD:0] diff;
    dstep_t      y;
    y    = x;
    r2   = {x.rem, x.low[QB-1]};
    diff = r2 - {1'b0, x.dd};
    if (r2 >= {1'b0, x.dd}) begin
      y.rem = diff[WD-1:0];
      y.q   = {x.q[QB-2:0], 1'b1};
    end else begin
      y.rem = r2[WD-1:0];
      y.q   = {x.q[QB-2:0], 1'b0};
    end
    y.low = {x.low[QB-2:0], 1'b0};
    return y;
  endfunction

  assign fin = st[QB];
  assign rnz = fin.rem != '0;
  assign qq  = {1'b0, fin.q} + {{QB{1'b0}}, rnz};

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a <= num[WN-1];
      mag_a <= num[WN-1] ? WN'(-num) : WN'(num);
      dd_a  <= dd;
      st[0].neg <= neg_a;
      st[0].big <= mag_a >= WN'({dd_a, {QB{1'b0}}});
      st[0].dd  <= dd_a;
      st[0].rem <= mag_a[QB +: WD];
      st[0].low <= mag_a[QB-1:0];
      st[0].q   <= '0;
      for (int j = 0; j < QB; j++) begin
        st[j+1] <= div_step(st[j]);
      end
      if (fin.neg) begin
        if (fin.big || qq > {1'b0, rmt_pkg::SAT_MIN}) begin
          res <= rmt_pkg::SAT_MIN;
        end else begin
          res <= 32'(-qq);
        end
      end else begin
        if (fin.big || fin.q[QB-1]) begin
          res <= rmt_pkg::SAT_MAX;
        end else begin
          res <= fin.q;
        end
      end
    end
  end

endmodule

// ===== design/rmt_front.sv =====
module rmt_front (
  input  logic                clk,
  input  logic                rst,
  input  rmt_pkg::rays_t      rays,
  input  logic                push,
  output logic                full,
  input  logic [31:0]         thr,
  output rmt_pkg::job_t       job,
  output logic                job_valid,
  input  logic                job_ready
);

  localparam int WP   = rmt_pkg::W_P;
  localparam int WDOT = rmt_pkg::W_DOT;
  localparam int WDEN = rmt_pkg::W_DEN;
  localparam int ML   = (WDOT + rmt_pkg::MUL_DIGIT - 1) / rmt_pkg::MUL_DIGIT;

  logic en;
  logic v0, v1, v2, v3, v9, vl;
  logic [ML-1:0] mv;

  rmt_pkg::rays_t  in_r;
  rmt_pkg::coord_t o1 [3];
  rmt_pkg::coord_t o2 [3];
  rmt_pkg::coord_t d1 [3];
  rmt_pkg::coord_t d2 [3];

  rmt_pkg::sum_t [2:0] w1;
  rmt_pkg::side_t side1, side2, side3, side9;
  rmt_pkg::side_t mside [ML];

  logic signed [WP-1:0] pa [3];
  logic signed [WP-1:0] pb [3];
  logic signed [WP-1:0] pc [3];
  logic signed [WP-1:0] pd [3];
  logic signed [WP-1:0] pe [3];

  logic signed [WDOT-1:0] a3, b3, c3, d3, e3;
  logic signed [WDEN-1:0] p_ac, p_bb, p_be, p_cd, p_ae, p_bd;
  logic signed [WDEN-1:0] den9, n19, n29;

  logic            den_neg;
  logic [WDEN-1:0] den_abs;
  logic [WDEN-1:0] thr_w;
  logic            par;
  rmt_pkg::job_t   job_r;

  assign en        = !vl || job_ready;
  assign full      = !en;
  assign job_valid = vl;
  assign job       = job_r;

  always_comb begin
    o1[0] = in_r.origin_one_x;    o1[1] = in_r.origin_one_y;    o1[2] = in_r.origin_one_z;
    d1[0] = in_r.direction_one_x; d1[1] = in_r.direction_one_y; d1[2] = in_r.direction_one_z;
    o2[0] = in_r.origin_two_x;    o2[1] = in_r.origin_two_y;    o2[2] = in_r.origin_two_z;
    d2[0] = in_r.direction_two_x; d2[1] = in_r.direction_two_y; d2[2] = in_r.direction_two_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      mv <= '0;
      v9 <= 1'b0;
      vl <= 1'b0;
    end else if (en) begin
      v0 <= push;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      mv <= {mv[ML-2:0], v3};
      v9 <= mv[ML-1];
      vl <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= rays;
      for (int k = 0; k < 3; k++) begin
        w1[k]       <= {o1[k][31], o1[k]} - {o2[k][31], o2[k]};
        side1.s[k]  <= {o1[k][31], o1[k]} + {o2[k][31], o2[k]};
        side1.d1[k] <= d1[k];
        side1.d2[k] <= d2[k];
      end
      for (int k = 0; k < 3; k++) begin
        pa[k] <= $signed(side1.d1[k]) * $signed(side1.d1[k]);
        pb[k] <= $signed(side1.d1[k]) * $signed(side1.d2[k]);
        pc[k] <= $signed(side1.d2[k]) * $signed(side1.d2[k]);
        pd[k] <= $signed(side1.d1[k]) * $signed(w1[k]);
        pe[k] <= $signed(side1.d2[k]) * $signed(w1[k]);
      end
      side2 <= side1;
      a3 <= WDOT'(pa[0]) + WDOT'(pa[1]) + WDOT'(pa[2]);
      b3 <= WDOT'(pb[0]) + WDOT'(pb[1]) + WDOT'(pb[2]);
      c3 <= WDOT'(pc[0]) + WDOT'(pc[1]) + WDOT'(pc[2]);
      d3 <= WDOT'(pd[0]) + WDOT'(pd[1]) + WDOT'(pd[2]);
      e3 <= WDOT'(pe[0]) + WDOT'(pe[1]) + WDOT'(pe[2]);
      side3 <= side2;
      mside[0] <= side3;
      for (int i = 1; i < ML; i++) begin
        mside[i] <= mside[i-1];
      end
      den9  <= p_ac - p_bb;
      n19   <= p_be - p_cd;
      n29   <= p_ae - p_bd;
      side9 <= mside[ML-1];
      job_r.par  <= par;
      job_r.den  <= $signed(den_abs);
      job_r.n1   <= den_neg ? -n19 : n19;
      job_r.n2   <= den_neg ? -n29 : n29;
      job_r.side <= side9;
    end
  end

  rmt_mul #(.WA(WDOT), .WB(WDOT), .DIGIT(rmt_pkg::MUL_DIGIT)) u_ac (
    .clk(clk), .en(en), .a(a3), .b(c3), .p(p_ac));
  rmt_mul #(.WA(WDOT), .WB(WDOT), .DIGIT(rmt_pkg::MUL_DIGIT)) u_bb (
    .clk(clk), .en(en), .a(b3), .b(b3), .p(p_bb));
  rmt_mul #(.WA(WDOT), .WB(WDOT), .DIGIT(rmt_pkg::MUL_DIGIT)) u_be (
    .clk(clk), .en(en), .a(b3), .b(e3), .p(p_be));
  rmt_mul #(.WA(WDOT), .WB(WDOT), .DIGIT(rmt_pkg::MUL_DIGIT)) u_cd (
    .clk(clk), .en(en), .a(c3), .b(d3), .p(p_cd));
  rmt_mul #(.WA(WDOT), .WB(WDOT), .DIGIT(rmt_pkg::MUL_DIGIT)) u_ae (
    .clk(clk), .en(en), .a(a3), .b(e3), .p(p_ae));
  rmt_mul #(.WA(WDOT), .WB(WDOT), .DIGIT(rmt_pkg::MUL_DIGIT)) u_bd (
    .clk(clk), .en(en), .a(b3), .b(d3), .p(p_bd));

  // parallel when |D| below threshold in Q64.64, or D exactly zero
  always_comb begin
    den_neg = den9[WDEN-1];
    den_abs = den_neg ? WDEN'(-den9) : WDEN'(den9);
    thr_w   = {{(WDEN-64){1'b0}}, thr, 32'h0};
    par     = (den9 == '0) || (den_abs < thr_w);
  end

endmodule

// ===== design/rmt_back.sv =====
module rmt_back (
  input  logic             clk,
  input  logic             rst,
  input  rmt_pkg::job_t    job,
  input  logic             job_valid,
  output logic             job_take,
  output rmt_pkg::point_t  result,
  output logic             empty,
  input  logic             pop
);

  localparam int WDEN = rmt_pkg::W_DEN;
  localparam int WS   = rmt_pkg::W_S;
  localparam int WNUM = rmt_pkg::W_NUM;
  localparam int WDD  = rmt_pkg::W_DD;
  localparam int DL   = rmt_pkg::DIV_LAT;
  localparam int ML   = (WDEN + rmt_pkg::MUL_DIGIT - 1) / rmt_pkg::MUL_DIGIT;

  typedef struct packed {
    logic                   par;
    logic signed [WDEN-1:0] den;
    rmt_pkg::sum_t [2:0]    s;
  } bside_t;

  typedef struct packed {
    logic         par;
    logic [2:0][31:0] mid;
  } dside_t;

  logic en;
  logic v0, v4, vl;
  logic [ML-1:0] mv;
  logic [DL-1:0] dv;

  rmt_pkg::job_t jr;
  bside_t        bs [ML];
  dside_t        ds [DL];

  logic signed [WDEN+WS-1:0] ps  [3];
  logic signed [WDEN+WS-1:0] pn1 [3];
  logic signed [WDEN+WS-1:0] pn2 [3];
  logic signed [WNUM-1:0]    num4 [3];
  logic        [WDD-1:0]     dd4;
  logic        [31:0]        q [3];
  logic        [WS:0]        s1 [3];
  dside_t                    ds4;

  assign en       = !vl || pop;
  assign job_take = en && job_valid;
  assign vl       = dv[DL-1];
  assign empty    = !vl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      mv <= '0;
      v4 <= 1'b0;
      dv <= '0;
    end else if (en) begin
      v0 <= job_valid;
      mv <= {mv[ML-2:0], v0};
      v4 <= mv[ML-1];
      dv <= {dv[DL-2:0], v4};
    end
  end

  generate
    for (genvar k = 0; k < 3; k++) begin : g_lane
      rmt_mul #(.WA(WS), .WB(WDEN), .DIGIT(rmt_pkg::MUL_DIGIT)) u_s (
        .clk(clk), .en(en), .a(jr.side.s[k]), .b(jr.den), .p(ps[k]));
      rmt_mul #(.WA(WS), .WB(WDEN), .DIGIT(rmt_pkg::MUL_DIGIT)) u_n1 (
        .clk(clk), .en(en), .a({jr.side.d1[k][31], jr.side.d1[k]}),
        .b(jr.n1), .p(pn1[k]));
      rmt_mul #(.WA(WS), .WB(WDEN), .DIGIT(rmt_pkg::MUL_DIGIT)) u_n2 (
        .clk(clk), .en(en), .a({jr.side.d2[k][31], jr.side.d2[k]}),
        .b(jr.n2), .p(pn2[k]));
      rmt_div u_div (
        .clk(clk), .en(en), .num(num4[k]), .dd(dd4), .res(q[k]));
    end
  endgenerate

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1[k] = {bs[ML-1].s[k][WS-1], bs[ML-1].s[k]} + (WS+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      jr        <= job;
      bs[0].par <= jr.par;
      bs[0].den <= jr.den;
      bs[0].s   <= jr.side.s;
      for (int i = 1; i < ML; i++) begin
        bs[i] <= bs[i-1];
      end
      for (int k = 0; k < 3; k++) begin
        num4[k]    <= WNUM'(ps[k]) + WNUM'(pn1[k]) + WNUM'(pn2[k]) + WNUM'(bs[ML-1].den);
        ds4.mid[k] <= s1[k][WS-1:1];
      end
      dd4     <= {bs[ML-1].den[WDD-2:0], 1'b0};
      ds4.par <= bs[ML-1].par;
      ds[0]   <= ds4;
      for (int i = 1; i < DL; i++) begin
        ds[i] <= ds[i-1];
      end
    end
  end

  always_comb begin
    result.rays_parallel = ds[DL-1].par;
    result.point_x = ds[DL-1].par ? ds[DL-1].mid[0] : q[0];
    result.point_y = ds[DL-1].par ? ds[DL-1].mid[1] : q[1];
    result.point_z = ds[DL-1].par ? ds[DL-1].mid[2] : q[2];
  end

endmodule

// ===== design/ray_midpoint_triangulate_core.sv =====
// Two-ray midpoint triangulation, one ray pair per beat.
// Input channel: push / full. A beat carries two rays (origin, direction) in
//   signed Q16.16 and is taken on a clock edge with push high and full low.
// Result channel: empty / pop. While empty is low the oldest point is on
//   result; it leaves on an edge with pop high. rays_parallel marks beats
//   where the origin midpoint was returned.
// Config channel: cfg_valid / cfg_ready / cfg_data writes the parallel
//   threshold (Q32.32 fraction units); cfg_ready is always high.
// Throughput: one beat per cycle while full is low.
// Datapath: the front (dot products, 5-stage 68x68 digit multipliers, the
//   parallel test), then the queue, then the back (9-stage coordinate
//   multipliers and a 35-stage radix-2 divider, 32 quotient bits).
// A stalled result freezes the back pipeline only; the front keeps working
//   into the queue until it fills, then raises full.
// Reset (rst, synchronous) empties both pipelines and the queue and sets the
//   threshold to 1.
module ray_midpoint_triangulate_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  rmt_pkg::rays_t   rays,
  input  logic             push,
  output logic             full,
  output rmt_pkg::point_t  result,
  output logic             empty,
  input  logic             pop,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [31:0]   thr;
  rmt_pkg::job_t f_job, b_job;
  logic          f_valid, f_ready, b_take;
  logic          q_full, q_empty, q_push, q_pop;
  rmt_pkg::job_t mem [QUEUE_DEPTH];
  logic [PW-1:0] wp, rp;
  logic [CW-1:0] count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 32'd1;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  rmt_front u_front (
    .clk(clk), .rst(rst), .rays(rays), .push(push), .full(full), .thr(thr),
    .job(f_job), .job_valid(f_valid), .job_ready(f_ready));

  assign q_full  = count == CW'(QUEUE_DEPTH);
  assign q_empty = count == '0;
  assign f_ready = !q_full;
  assign q_push  = f_valid && !q_full;
  assign q_pop   = b_take;
  assign b_job   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (q_push) begin
        wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (q_pop) begin
        rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      if (q_push && !q_pop) begin
        count <= count + CW'(1);
      end else if (q_pop && !q_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem[wp] <= f_job;
    end
  end

  rmt_back u_back (
    .clk(clk), .rst(rst), .job(b_job), .job_valid(!q_empty), .job_take(b_take),
    .result(result), .empty(empty), .pop(pop));

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (f_valid && q_full && !q_pop) |=> f_valid)
    else $error("front dropped a job while queue full");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending right after reset");

  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("full right after reset");

endmodule

// ===== dv/ray_midpoint_triangulate_checker.sv =====
`timescale 1ns / 1ps

module ray_midpoint_triangulate_checker (
  input  logic             clk,
  input  logic             rst,
  input  rmt_pkg::rays_t   rays,
  input  logic             push,
  input  logic             full,
  input  rmt_pkg::point_t  result,
  input  logic             empty,
  input  logic             pop,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [31:0]      cfg_data,
  output int               pending,
  output int               errors
);

  typedef logic signed [255:0] big_t;

  logic [31:0]     threshold;
  rmt_pkg::point_t expected_points[$];

  function automatic big_t floor_div_big(big_t num, big_t den);
    big_t mag;
    big_t quo;
    if (num >= 0) begin
      quo = num / den;
    end else begin
      mag = -num;
      quo = mag / den;
      if (mag % den != 0) quo = quo + 1;
      quo = -quo;
    end
    return quo;
  endfunction

  function automatic rmt_pkg::point_t triangulate(rmt_pkg::rays_t r, logic [31:0] thr);
    big_t o1[3], d1[3], o2[3], d2[3], w[3];
    big_t a, b, c, d, e, den, n1, n2, q, quo, absden, thr_w;
    logic signed [33:0] s;
    logic signed [31:0] res[3];
    rmt_pkg::point_t p;
    o1[0] = r.origin_one_x;    o1[1] = r.origin_one_y;    o1[2] = r.origin_one_z;
    d1[0] = r.direction_one_x; d1[1] = r.direction_one_y; d1[2] = r.direction_one_z;
    o2[0] = r.origin_two_x;    o2[1] = r.origin_two_y;    o2[2] = r.origin_two_z;
    d2[0] = r.direction_two_x; d2[1] = r.direction_two_y; d2[2] = r.direction_two_z;
    for (int k = 0; k < 3; k++) w[k] = o1[k] - o2[k];
    a = d1[0]*d1[0] + d1[1]*d1[1] + d1[2]*d1[2];
    b = d1[0]*d2[0] + d1[1]*d2[1] + d1[2]*d2[2];
    c = d2[0]*d2[0] + d2[1]*d2[1] + d2[2]*d2[2];
    d = d1[0]*w[0] + d1[1]*w[1] + d1[2]*w[2];
    e = d2[0]*w[0] + d2[1]*w[1] + d2[2]*w[2];
    den = a*c - b*b;
    n1 = b*e - c*d;
    n2 = a*e - b*d;
    absden = (den < 0) ? -den : den;
    thr_w = '0;
    thr_w[63:32] = thr;
    if (den == 0 || absden < thr_w) begin
      for (int k = 0; k < 3; k++) begin
        s = o1[k][33:0] + o2[k][33:0] + 34'sd1;
        s = s >>> 1;
        res[k] = s[31:0];
      end
      p.rays_parallel = 1'b1;
    end else begin
      if (den < 0) begin
        den = -den;
        n1 = -n1;
        n2 = -n2;
      end
      for (int k = 0; k < 3; k++) begin
        q = (o1[k] + o2[k]) * den + n1 * d1[k] + n2 * d2[k];
        quo = floor_div_big(q + den, den + den);
        if (quo > 256'sh7FFFFFFF) res[k] = rmt_pkg::SAT_MAX;
        else if (quo < -256'sh80000000) res[k] = rmt_pkg::SAT_MIN;
        else res[k] = quo[31:0];
      end
      p.rays_parallel = 1'b0;
    end
    p.point_x = res[0];
    p.point_y = res[1];
    p.point_z = res[2];
    return p;
  endfunction

  always @(posedge clk) begin
    rmt_pkg::point_t want;
    if (rst) begin
      threshold = 32'd1;
      expected_points.delete();
      errors = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          errors++;
        end else begin
          want = expected_points.pop_front();
          if (result.point_x !== want.point_x) begin
            $display("%0t: point_x exp %h act %h", $time, want.point_x, result.point_x);
            errors++;
          end
          if (result.point_y !== want.point_y) begin
            $display("%0t: point_y exp %h act %h", $time, want.point_y, result.point_y);
            errors++;
          end
          if (result.point_z !== want.point_z) begin
            $display("%0t: point_z exp %h act %h", $time, want.point_z, result.point_z);
            errors++;
          end
          if (result.rays_parallel !== want.rays_parallel) begin
            $display("%0t: rays_parallel exp %b act %b", $time, want.rays_parallel,
                     result.rays_parallel);
            errors++;
          end
        end
      end
      if (push && !full) expected_points.push_back(triangulate(rays, threshold));
      if (cfg_valid && cfg_ready) threshold = cfg_data;
    end
    pending = expected_points.size();
  end

  initial begin
    pending = 0;
    errors = 0;
    threshold = 32'd1;
  end

endmodule

// ===== dv/ray_midpoint_triangulate_core_tb.sv =====
`timescale 1ns / 1ps

module ray_midpoint_triangulate_core_tb;

  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  rmt_pkg::rays_t  rays = '0;
  logic            push = 1'b0;
  logic            full;
  rmt_pkg::point_t result;
  logic            empty;
  logic            pop = 1'b0;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [31:0]     cfg_data = '0;
  int              pending;
  int              errors;
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ray_midpoint_triangulate_core uut (
    .clk(clk), .rst(rst), .rays(rays), .push(push), .full(full),
    .result(result), .empty(empty), .pop(pop),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ray_midpoint_triangulate_checker chk (
    .clk(clk), .rst(rst), .rays(rays), .push(push), .full(full),
    .result(result), .empty(empty), .pop(pop),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_rays(rmt_pkg::rays_t r);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    rays <= r;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain;
    push <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] small_val(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  function automatic rmt_pkg::rays_t random_rays(int mode);
    rmt_pkg::rays_t r;
    int    sc;
    case (mode)
      0: r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      1: begin
        r.origin_one_x = small_val(1 << 22); r.origin_one_y = small_val(1 << 22);
        r.origin_one_z = small_val(1 << 22); r.origin_two_x = small_val(1 << 22);
        r.origin_two_y = small_val(1 << 22); r.origin_two_z = small_val(1 << 22);
        r.direction_one_x = small_val(1 << 17); r.direction_one_y = small_val(1 << 17);
        r.direction_one_z = small_val(1 << 17); r.direction_two_x = small_val(1 << 17);
        r.direction_two_y = small_val(1 << 17); r.direction_two_z = small_val(1 << 17);
      end
      default: begin
        r = random_rays(1);
        sc = $urandom_range(1, 3);
        r.direction_two_x = r.direction_one_x * sc + small_val(2);
        r.direction_two_y = r.direction_one_y * sc + small_val(2);
        r.direction_two_z = r.direction_one_z * sc + small_val(2);
      end
    endcase
    return r;
  endfunction

  task automatic directed_items;
    rmt_pkg::rays_t r;
    send_rays('0);
    send_rays('1);
    r = {12{32'h7FFF_FFFF}};
    send_rays(r);
    r = {12{32'h8000_0000}};
    send_rays(r);
    r = {{3{32'h7FFF_FFFF}}, 32'h8000_0000, 32'h0, 32'h0,
         {3{32'h8000_0000}}, 32'h0, 32'h7FFF_FFFF, 32'h0};
    send_rays(r);
    r = '0;
    r.direction_one_x = 32'h0001_0000;
    r.origin_two_y = 32'h0002_0000;
    r.origin_two_z = 32'h0001_0000;
    r.direction_two_y = 32'h0001_0000;
    send_rays(r);
    r.direction_two_x = 32'h0001_0000;
    r.direction_two_y = 32'h0;
    send_rays(r);
    r.origin_one_x = 32'sh0000_0001;
    r.origin_two_x = 32'sh0000_0000;
    send_rays(r);
    r.origin_one_x = -32'sd3;
    send_rays(r);
    r = '0;
    r.direction_one_x = 32'h0000_0001;
    r.direction_two_y = 32'h0000_0001;
    r.origin_one_z = 32'h7FFF_FFFF;
    r.origin_two_z = 32'h7FFF_FFFF;
    send_rays(r);
    r.direction_one_z = 32'h8000_0000;
    r.direction_two_x = 32'h7FFF_FFFF;
    send_rays(r);
    for (int i = 0; i < 4; i++) send_rays(random_rays(2));
  endtask

  initial begin
    logic [31:0] thresholds[5];
    thresholds[0] = 32'd1;
    thresholds[1] = 32'd0;
    thresholds[2] = 32'hFFFF_FFFF;
    thresholds[3] = $urandom_range(1 << 20);
    thresholds[4] = $urandom;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int t = 0; t < 5; t++) begin
      if (t != 0) write_threshold(thresholds[t]);
      idle_pct = 0;
      stall_pct = 0;
      directed_items();
      for (int i = 0; i < 150; i++) begin
        case ((i / 30) % 5)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 62; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 62; end
          3: begin idle_pct = 12; stall_pct = 12; end
          default: begin idle_pct = 0; stall_pct = 30; end
        endcase
        if (i == 75) begin
          push <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_rays(random_rays($urandom_range(9) < 2 ? 0 : ($urandom_range(3) == 0 ? 2 : 1)));
      end
      stall_pct = 20;
      drain();
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
